>>> rtl/aet_pkg.sv
package aet_pkg;

	localparam int MAX_EVENTS_DEF  = 16;
	localparam int DAY_SECONDS_DEF = 86400;

	// command codes
	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_ADD    = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_MODIFY = 3'd3;
	localparam logic [2:0] CMD_SHIFT  = 3'd4;

	// entry phases
	localparam logic [2:0] PH_SCHED = 3'd0;
	localparam logic [2:0] PH_PRE   = 3'd1;
	localparam logic [2:0] PH_RUN   = 3'd2;
	localparam logic [2:0] PH_DONE  = 3'd3;
	localparam logic [2:0] PH_TERM  = 3'd4;

	// repeat modes
	localparam logic [2:0] REP_DAILY      = 3'd1;
	localparam logic [2:0] REP_WEEKLY     = 3'd2;
	localparam logic [2:0] REP_BIWEEKLY   = 3'd3;
	localparam logic [2:0] REP_FOURWEEKLY = 3'd4;
	localparam logic [2:0] REP_MONTHLY    = 3'd5;

	// result actions
	localparam logic [2:0] ACT_OK       = 3'd0;
	localparam logic [2:0] ACT_NOTFOUND = 3'd1;
	localparam logic [2:0] ACT_FULL     = 3'd2;
	localparam logic [2:0] ACT_ANNOUNCE = 3'd3;
	localparam logic [2:0] ACT_FIRE     = 3'd4;
	localparam logic [2:0] ACT_STOP     = 3'd5;
	localparam logic [2:0] ACT_RESCHED  = 3'd6;
	localparam logic [2:0] ACT_FREED    = 3'd7;

	// bit positions in the pending-action mask, in emission order
	localparam logic [2:0] MB_ANN      = 3'd0;
	localparam logic [2:0] MB_FIRE     = 3'd1;
	localparam logic [2:0] MB_STOP     = 3'd2;
	localparam logic [2:0] MB_RESCH    = 3'd3;
	localparam logic [2:0] MB_FREED    = 3'd4;
	localparam logic [2:0] MB_OK       = 3'd5;
	localparam logic [2:0] MB_NOTFOUND = 3'd6;
	localparam logic [2:0] MB_FULL     = 3'd7;

	typedef struct packed {
		logic [31:0] ann;
		logic [31:0] alm;
		logic [31:0] stp;
		logic [2:0]  phase;
		logic [2:0]  rep;
	} aet_rec_t;

	localparam int REC_W = $bits(aet_rec_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_FIND,
		ST_EXEC,
		ST_EMIT,
		ST_FLUSH
	} aet_state_t;

	typedef struct packed {
		logic match;
		logic free;
		logic next;
	} aet_hits_t;

	function automatic logic [2:0] lowest_bit(input logic [7:0] m);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (m[i]) r = 3'(i);
		end
		return r;
	endfunction

	function automatic logic [2:0] act_of_bit(input logic [2:0] b);
		logic [2:0] a;
		case (b)
			MB_ANN:      a = ACT_ANNOUNCE;
			MB_FIRE:     a = ACT_FIRE;
			MB_STOP:     a = ACT_STOP;
			MB_RESCH:    a = ACT_RESCHED;
			MB_FREED:    a = ACT_FREED;
			MB_OK:       a = ACT_OK;
			MB_NOTFOUND: a = ACT_NOTFOUND;
			default:     a = ACT_FULL;
		endcase
		return a;
	endfunction

endpackage

>>> rtl/alarm_event_table_core.sv
// Channel  | Dir | Transfer when       | Content
// ---------+-----+---------------------+-----------------------------------------
// s_*      | in  | s_tvalid & s_tready | tuser command, tdata event fields
// m_*      | out | m_tvalid & m_tready | tdata result_id, tuser action, tlast last
//
// One command at a time; s_tready stays low until it is through. States: add
// and not-found LOOKUP, EMIT, FLUSH; remove, modify, shift LOOKUP, EXEC, EMIT,
// FLUSH; unused codes LOOKUP, FLUSH; tick LOOKUP, then FIND, EXEC, EMIT per valid
// entry in id order, then FLUSH. EXEC writes the updated record back to the RAM.
// Reset clears the valid bits and the id counter; the record RAM holds no reset.
// A stalled m_* side holds the sequencer; s_tready rises again as soon as
// the final result of a command sits in the output register.
module alarm_event_table_core #(
	parameter int MAX_EVENTS  = aet_pkg::MAX_EVENTS_DEF,
	parameter int DAY_SECONDS = aet_pkg::DAY_SECONDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [15:0] event_id, [47:16] now_seconds, [79:48] announce_time,
	// [111:80] alarm_time, [143:112] stop_time, [146:144] repeat_mode, rest 0
	input  logic [151:0] s_tdata,
	// [2:0] command
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] result_id
	output logic [15:0]  m_tdata,
	// [2:0] action
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);
	import aet_pkg::*;

	localparam int SLOT_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam logic [31:0] PER_1  = 32'(DAY_SECONDS);
	localparam logic [31:0] PER_7  = 32'(DAY_SECONDS * 7);
	localparam logic [31:0] PER_14 = 32'(DAY_SECONDS * 14);
	localparam logic [31:0] PER_28 = 32'(DAY_SECONDS * 28);

	aet_state_t state_q, state_d;

	// latched command
	logic [2:0]  cmd_q;
	logic [15:0] eid_q;
	logic [31:0] now_q, ta_q, tl_q, ts_q;
	logic [2:0]  rep_q;

	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [15:0]       prev_q, prev_d;
	logic              have_prev_q, have_prev_d;
	logic [7:0]        mask_q, mask_d;
	logic [15:0]       res_id_q, res_id_d;
	logic [15:0]       id_cnt_q, id_cnt_d;

	// one result held back so the final one can carry tlast
	logic        pend_v_q, pend_v_d;
	logic [15:0] pend_id_q, pend_id_d;
	logic [2:0]  pend_act_q, pend_act_d;

	logic        out_v_q;
	logic [15:0] out_id_q;
	logic [2:0]  out_act_q;
	logic        out_last_q;
	logic        load_out, load_last;
	logic        out_free;

	// RAM and directory hookup
	logic              ram_we;
	logic [SLOT_W-1:0] ram_raddr, ram_waddr;
	logic [REC_W-1:0]  ram_rdata;
	aet_rec_t          rec_rd, rec_wr;

	aet_hits_t         hits;
	logic [SLOT_W-1:0] match_slot, free_slot, next_slot;
	logic [15:0]       next_id, query_id, nid;
	logic              set_en, clr_en;

	// per-entry evaluation
	aet_rec_t    tk_rec, sh_rec;
	logic [7:0]  tk_mask;
	logic        tk_free;
	logic [31:0] per;
	logic [2:0]  ph;
	logic [2:0]  bsel;

	assign nid      = id_cnt_q + 16'd1;
	assign query_id = (cmd_q == CMD_ADD) ? nid : eid_q;
	assign rec_rd   = aet_rec_t'(ram_rdata);
	assign out_free = !out_v_q || m_tready;
	assign bsel     = lowest_bit(mask_q);

	aet_ram #(.WIDTH(REC_W), .DEPTH(MAX_EVENTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rec_wr),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	aet_dir #(.MAX_EVENTS(MAX_EVENTS)) u_dir (
		.clk        (clk),
		.arst_n     (arst_n),
		.set_en     (set_en),
		.set_slot   (slot_d),
		.set_id     (nid),
		.clr_en     (clr_en),
		.clr_slot   (slot_q),
		.query_id   (query_id),
		.prev_id    (prev_q),
		.have_prev  (have_prev_q),
		.hits       (hits),
		.match_slot (match_slot),
		.free_slot  (free_slot),
		.next_slot  (next_slot),
		.next_id    (next_id)
	);

	// tick evaluation of one record: announce, fire, stop, then repeat or free
	always_comb begin
		case (rec_rd.rep)
			REP_DAILY:      per = PER_1;
			REP_WEEKLY:     per = PER_7;
			REP_BIWEEKLY:   per = PER_14;
			REP_FOURWEEKLY: per = PER_28;
			REP_MONTHLY:    per = PER_28;
			default:        per = 32'd0;
		endcase
		tk_rec  = rec_rd;
		tk_mask = '0;
		tk_free = 1'b0;
		ph      = rec_rd.phase;
		if (rec_rd.ann != 32'd0 && ph == PH_SCHED && rec_rd.ann <= now_q) begin
			ph = PH_PRE;
			tk_mask[MB_ANN] = 1'b1;
		end
		if (rec_rd.alm != 32'd0 && (ph == PH_SCHED || ph == PH_PRE) && rec_rd.alm <= now_q) begin
			ph = (rec_rd.stp == 32'd0) ? PH_DONE : PH_RUN;
			tk_mask[MB_FIRE] = 1'b1;
		end
		if (rec_rd.stp != 32'd0 && ph == PH_RUN && rec_rd.stp <= now_q) begin
			ph = PH_DONE;
			tk_mask[MB_STOP] = 1'b1;
		end
		if (ph == PH_DONE) begin
			if (per != 32'd0) begin
				if (rec_rd.ann != 32'd0) tk_rec.ann = rec_rd.ann + per;
				if (rec_rd.alm != 32'd0) tk_rec.alm = rec_rd.alm + per;
				if (rec_rd.stp != 32'd0) tk_rec.stp = rec_rd.stp + per;
				ph = PH_SCHED;
				tk_mask[MB_RESCH] = 1'b1;
			end else begin
				ph = PH_TERM;
			end
		end
		if (ph == PH_TERM) begin
			tk_free = 1'b1;
			tk_mask[MB_FREED] = 1'b1;
		end
		tk_rec.phase = ph;

		// shift: offset each time in use
		sh_rec       = rec_rd;
		sh_rec.phase = PH_SCHED;
		if (rec_rd.ann != 32'd0) sh_rec.ann = rec_rd.ann + ta_q;
		if (rec_rd.alm != 32'd0) sh_rec.alm = rec_rd.alm + tl_q;
		if (rec_rd.stp != 32'd0) sh_rec.stp = rec_rd.stp + ts_q;
	end

	// sequencer
	always_comb begin
		state_d     = state_q;
		slot_d      = slot_q;
		prev_d      = prev_q;
		have_prev_d = have_prev_q;
		mask_d      = mask_q;
		res_id_d    = res_id_q;
		id_cnt_d    = id_cnt_q;
		pend_v_d    = pend_v_q;
		pend_id_d   = pend_id_q;
		pend_act_d  = pend_act_q;
		load_out    = 1'b0;
		load_last   = 1'b0;
		ram_we      = 1'b0;
		ram_raddr   = slot_q;
		ram_waddr   = slot_q;
		rec_wr      = rec_rd;
		set_en      = 1'b0;
		clr_en      = 1'b0;
		s_tready    = 1'b0;

		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				mask_d = '0;
				case (cmd_q)
					CMD_TICK: begin
						have_prev_d = 1'b0;
						state_d     = ST_FIND;
					end
					CMD_ADD: begin
						state_d = ST_EMIT;
						if (hits.match || hits.free) begin
							// write the new record; the directory takes id and valid
							slot_d       = hits.match ? match_slot : free_slot;
							set_en       = 1'b1;
							id_cnt_d     = nid;
							res_id_d     = nid;
							mask_d[MB_OK] = 1'b1;
						end else begin
							res_id_d        = 16'd0;
							mask_d[MB_FULL] = 1'b1;
						end
					end
					CMD_REMOVE, CMD_MODIFY, CMD_SHIFT: begin
						if (hits.match) begin
							slot_d    = match_slot;
							ram_raddr = match_slot;
							res_id_d  = eid_q;
							state_d   = ST_EXEC;
						end else begin
							res_id_d            = 16'd0;
							mask_d[MB_NOTFOUND] = 1'b1;
							state_d             = ST_EMIT;
						end
					end
					default: state_d = ST_FLUSH;
				endcase
			end
			ST_FIND: begin
				if (hits.next) begin
					slot_d      = next_slot;
					ram_raddr   = next_slot;
					prev_d      = next_id;
					have_prev_d = 1'b1;
					res_id_d    = next_id;
					state_d     = ST_EXEC;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_EXEC: begin
				// read data of slot_q is here; write back the updated record
				ram_we  = 1'b1;
				state_d = ST_EMIT;
				case (cmd_q)
					CMD_TICK: begin
						rec_wr = tk_rec;
						mask_d = tk_mask;
						clr_en = tk_free;
					end
					CMD_REMOVE: begin
						rec_wr       = rec_rd;
						rec_wr.phase = PH_TERM;
						mask_d[MB_STOP] = (rec_rd.phase == PH_RUN) && (rec_rd.stp != 32'd0);
						mask_d[MB_OK]   = 1'b1;
					end
					CMD_MODIFY: begin
						rec_wr        = '{ann: ta_q, alm: tl_q, stp: ts_q,
						                  phase: PH_SCHED, rep: rep_q};
						mask_d[MB_OK] = 1'b1;
					end
					default: begin
						rec_wr        = sh_rec;
						mask_d[MB_OK] = 1'b1;
					end
				endcase
			end
			ST_EMIT: begin
				if (mask_q == 8'd0) begin
					state_d = (cmd_q == CMD_TICK) ? ST_FIND : ST_FLUSH;
				end else if (out_free) begin
					// push the held result out, hold the new one
					load_out     = pend_v_q;
					pend_v_d     = 1'b1;
					pend_id_d    = res_id_q;
					pend_act_d   = act_of_bit(bsel);
					mask_d[bsel] = 1'b0;
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					load_out  = 1'b1;
					load_last = 1'b1;
					pend_v_d  = 1'b0;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// the add record write shares the port with the read-modify-write path
		if (set_en) begin
			ram_we    = 1'b1;
			ram_waddr = slot_d;
			rec_wr    = '{ann: ta_q, alm: tl_q, stp: ts_q, phase: PH_SCHED, rep: rep_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			mask_q      <= '0;
			id_cnt_q    <= '0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			have_prev_q <= have_prev_d;
			mask_q      <= mask_d;
			id_cnt_q    <= id_cnt_d;
			pend_v_q    <= pend_v_d;
			if (load_out) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
		end
	end

	// latch the command fields at the input transfer
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= s_tuser;
			eid_q <= s_tdata[15:0];
			now_q <= s_tdata[47:16];
			ta_q  <= s_tdata[79:48];
			tl_q  <= s_tdata[111:80];
			ts_q  <= s_tdata[143:112];
			rep_q <= s_tdata[146:144];
		end
		slot_q     <= slot_d;
		prev_q     <= prev_d;
		res_id_q   <= res_id_d;
		pend_id_q  <= pend_id_d;
		pend_act_q <= pend_act_d;
		if (load_out) begin
			out_id_q   <= pend_id_q;
			out_act_q  <= pend_act_q;
			out_last_q <= load_last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_id_q;
	assign m_tuser  = out_act_q;
	assign m_tlast  = out_last_q;

	// input is taken only with no result held back
	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> !pend_v_q)
		else $error("input taken with a result still held");

	// a stalled output is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n) (out_v_q && !m_tready) |-> !load_out)
		else $error("output overwritten while stalled");

	// a write-back is always followed by emission, so no read overlaps it
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == ST_EXEC) |=> (state_q == ST_EMIT))
		else $error("record read issued right after write-back");

endmodule

>>> rtl/aet_ram.sv
module aet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/aet_dir.sv
module aet_dir #(
	parameter int MAX_EVENTS = aet_pkg::MAX_EVENTS_DEF,
	localparam int SLOT_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              set_en,
	input  logic [SLOT_W-1:0] set_slot,
	input  logic [15:0]       set_id,
	input  logic              clr_en,
	input  logic [SLOT_W-1:0] clr_slot,
	input  logic [15:0]       query_id,
	input  logic [15:0]       prev_id,
	input  logic              have_prev,
	output aet_pkg::aet_hits_t hits,
	output logic [SLOT_W-1:0] match_slot,
	output logic [SLOT_W-1:0] free_slot,
	output logic [SLOT_W-1:0] next_slot,
	output logic [15:0]       next_id
);
	import aet_pkg::*;

	localparam int LEVELS = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 0;
	localparam int PAD    = 1 << LEVELS;

	logic [MAX_EVENTS-1:0] valid_q;
	logic [15:0]           id_q [MAX_EVENTS];

	logic [16:0]       key [LEVELS+1][PAD];
	logic [SLOT_W-1:0] idx [LEVELS+1][PAD];

	logic match_hit, free_hit, next_hit;

	assign hits = '{match: match_hit, free: free_hit, next: next_hit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (clr_en) valid_q[clr_slot] <= 1'b0;
			if (set_en) valid_q[set_slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (set_en) id_q[set_slot] <= set_id;
	end

	// lowest-index match and lowest free slot
	always_comb begin
		match_hit  = 1'b0;
		free_hit   = 1'b0;
		match_slot = '0;
		free_slot  = '0;
		for (int i = MAX_EVENTS - 1; i >= 0; i--) begin
			if (valid_q[i] && id_q[i] == query_id) begin
				match_hit  = 1'b1;
				match_slot = SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free_hit  = 1'b1;
				free_slot = SLOT_W'(i);
			end
		end
	end

	// minimum-id tree over entries with id above the last one visited
	always_comb begin
		for (int l = 0; l <= LEVELS; l++) begin
			for (int n = 0; n < PAD; n++) begin
				key[l][n] = '1;
				idx[l][n] = '0;
			end
		end
		for (int n = 0; n < PAD; n++) begin
			if (n < MAX_EVENTS) begin
				if (valid_q[n] && (!have_prev || id_q[n] > prev_id))
					key[0][n] = {1'b0, id_q[n]};
				idx[0][n] = SLOT_W'(n);
			end
		end
		for (int l = 0; l < LEVELS; l++) begin
			for (int n = 0; n < (PAD >> (l + 1)); n++) begin
				if (key[l][2*n+1] < key[l][2*n]) begin
					key[l+1][n] = key[l][2*n+1];
					idx[l+1][n] = idx[l][2*n+1];
				end else begin
					key[l+1][n] = key[l][2*n];
					idx[l+1][n] = idx[l][2*n];
				end
			end
		end
		next_hit  = !key[LEVELS][0][16];
		next_slot = idx[LEVELS][0];
		next_id   = key[LEVELS][0][15:0];
	end

endmodule

>>> bench/aet_checker.sv
module aet_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [151:0] s_tdata,
	input  logic [2:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [15:0]  m_tdata,
	input  logic [2:0]   m_tuser,
	input  logic         m_tlast,
	output int           fail_count,
	output int           pending,
	output int           results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import aet_pkg::*;

	localparam int SLOTS = 16;
	localparam logic [31:0] DAY = 32'd86400;

	typedef struct packed {
		logic [15:0] id;
		logic [2:0]  act;
		logic        last;
	} action_t;

	action_t     due_actions[$];
	logic        tbl_valid[SLOTS];
	logic [15:0] tbl_id[SLOTS];
	logic [31:0] tbl_ann[SLOTS];
	logic [31:0] tbl_alm[SLOTS];
	logic [31:0] tbl_stp[SLOTS];
	logic [2:0]  tbl_phase[SLOTS];
	logic [2:0]  tbl_rep[SLOTS];
	logic [15:0] last_id;

	assign pending = due_actions.size();

	function automatic logic [31:0] repeat_period(input logic [2:0] mode);
		case (mode)
			REP_DAILY:      return DAY;
			REP_WEEKLY:     return DAY * 7;
			REP_BIWEEKLY:   return DAY * 14;
			REP_FOURWEEKLY: return DAY * 28;
			REP_MONTHLY:    return DAY * 28;
			default:        return 32'd0;
		endcase
	endfunction

	function automatic int slot_of(input logic [15:0] id);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i] && tbl_id[i] == id) return i;
		return -1;
	endfunction

	task automatic push_action(input logic [15:0] id, input logic [2:0] act);
		action_t a;
		a.id = id;
		a.act = act;
		a.last = 1'b0;
		due_actions = {due_actions, a};
	endtask

	task automatic bump_times(input int s, input logic [31:0] da, input logic [31:0] dl,
			input logic [31:0] ds);
		if (tbl_ann[s] != 0) tbl_ann[s] += da;
		if (tbl_alm[s] != 0) tbl_alm[s] += dl;
		if (tbl_stp[s] != 0) tbl_stp[s] += ds;
		tbl_phase[s] = PH_SCHED;
	endtask

	task automatic tick_slot(input int s, input logic [31:0] now);
		logic [15:0] id;
		logic [31:0] p;
		id = tbl_id[s];
		if (tbl_ann[s] != 0 && tbl_phase[s] == PH_SCHED && tbl_ann[s] <= now) begin
			tbl_phase[s] = PH_PRE;
			push_action(id, ACT_ANNOUNCE);
		end
		if (tbl_alm[s] != 0 && (tbl_phase[s] == PH_SCHED || tbl_phase[s] == PH_PRE)
				&& tbl_alm[s] <= now) begin
			tbl_phase[s] = (tbl_stp[s] == 0) ? PH_DONE : PH_RUN;
			push_action(id, ACT_FIRE);
		end
		if (tbl_stp[s] != 0 && tbl_phase[s] == PH_RUN && tbl_stp[s] <= now) begin
			push_action(id, ACT_STOP);
			tbl_phase[s] = PH_DONE;
		end
		if (tbl_phase[s] == PH_DONE) begin
			p = repeat_period(tbl_rep[s]);
			if (p != 0) begin
				bump_times(s, p, p, p);
				push_action(id, ACT_RESCHED);
			end else begin
				tbl_phase[s] = PH_TERM;
			end
		end
		if (tbl_phase[s] == PH_TERM) begin
			tbl_valid[s] = 1'b0;
			push_action(id, ACT_FREED);
		end
	endtask

	// Walk one command through the table and queue the actions it causes.
	task automatic apply_command(input logic [2:0] cmd, input logic [151:0] d);
		logic [15:0] eid, nid;
		logic [31:0] now, ta, tl, ts;
		logic [2:0]  rep;
		int          s, best, prev, before_n;
		eid = d[15:0];
		now = d[47:16];
		ta = d[79:48];
		tl = d[111:80];
		ts = d[143:112];
		rep = d[146:144];
		before_n = due_actions.size();
		case (cmd)
			CMD_TICK: begin
				prev = -1;
				forever begin
					best = -1;
					for (int i = 0; i < SLOTS; i++)
						if (tbl_valid[i] && int'(tbl_id[i]) > prev &&
								(best < 0 || tbl_id[i] < tbl_id[best]))
							best = i;
					if (best < 0) break;
					prev = int'(tbl_id[best]);
					tick_slot(best, now);
				end
			end
			CMD_ADD: begin
				nid = last_id + 16'd1;
				s = slot_of(nid);
				if (s < 0)
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!tbl_valid[i]) s = i;
				if (s < 0) begin
					push_action(16'd0, ACT_FULL);
				end else begin
					last_id = nid;
					tbl_valid[s] = 1'b1;
					tbl_id[s] = nid;
					tbl_ann[s] = ta;
					tbl_alm[s] = tl;
					tbl_stp[s] = ts;
					tbl_phase[s] = PH_SCHED;
					tbl_rep[s] = rep;
					push_action(nid, ACT_OK);
				end
			end
			CMD_REMOVE, CMD_MODIFY, CMD_SHIFT: begin
				s = slot_of(eid);
				if (s < 0) begin
					push_action(16'd0, ACT_NOTFOUND);
				end else begin
					if (cmd == CMD_REMOVE) begin
						if (tbl_phase[s] == PH_RUN && tbl_stp[s] != 0)
							push_action(eid, ACT_STOP);
						tbl_phase[s] = PH_TERM;
					end else if (cmd == CMD_MODIFY) begin
						tbl_ann[s] = ta;
						tbl_alm[s] = tl;
						tbl_stp[s] = ts;
						tbl_phase[s] = PH_SCHED;
						tbl_rep[s] = rep;
					end else begin
						bump_times(s, ta, tl, ts);
					end
					push_action(eid, ACT_OK);
				end
			end
			default: ;
		endcase
		if (due_actions.size() > before_n)
			due_actions[$].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		action_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
			last_id = 16'd0;
			due_actions.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			// Compare the output first: a result cannot depend on an input in the same edge.
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (due_actions.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result id=%0d action=%0d last=%0b",
							m_tdata, m_tuser, m_tlast);
				end else begin
					want = due_actions.pop_front();
					if (want.id !== m_tdata || want.act !== m_tuser || want.last !== m_tlast) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected id=%0d action=%0d last=%0b, got id=%0d action=%0d last=%0b",
								want.id, want.act, want.last, m_tdata, m_tuser, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready)
				apply_command(s_tuser, s_tdata);
		end
	end
endmodule

>>> bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import aet_pkg::*;

	localparam int  RANDOM_ITEMS = 384;
	localparam int  CYCLE_LIMIT  = 400000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [151:0] s_tdata = '0;
	logic [2:0]   s_tuser = CMD_TICK;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [15:0]  m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;
	int           fail_count, pending, results_seen;
	int           cycles = 0;
	int           send_idle_pct = 10;
	int           recv_idle_pct = 83;
	int           items_sent = 0;
	logic [31:0]  clock_now = 32'd1000;

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	alarm_event_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	aet_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	// Receiver: drop tready at random according to the current idle share.
	always @(posedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Hand one command to the block; hold until the transfer happens.
	task automatic send_cmd(input logic [2:0] cmd, input logic [15:0] id,
			input logic [31:0] now, input logic [31:0] ta, input logic [31:0] tl,
			input logic [31:0] ts, input logic [2:0] rep);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {5'd0, rep, ts, tl, ta, now, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// Pick a time near the running clock, sometimes zero or any 32-bit value.
	function automatic logic [31:0] near_time();
		case ($urandom_range(9))
			0:       return 32'd0;
			1:       return $urandom();
			default: return clock_now + $urandom_range(400) - 32'd100;
		endcase
	endfunction

	task automatic random_phase(input int count);
		int          k;
		logic [15:0] tgt;
		for (k = 0; k < count; k++) begin
			tgt = chk.last_id - 16'($urandom_range(18));
			case ($urandom_range(9))
				0, 1, 2: begin
					clock_now += $urandom_range(150);
					send_cmd(CMD_TICK, 16'($urandom()),
						($urandom_range(30) == 0) ? $urandom() : clock_now,
						$urandom(), $urandom(), $urandom(), 3'($urandom()));
				end
				3, 4, 5:
					send_cmd(CMD_ADD, 16'($urandom()), $urandom(), near_time(), near_time(),
						near_time(), 3'($urandom_range(7)));
				6:
					send_cmd(CMD_REMOVE, ($urandom_range(15) == 0) ? 16'($urandom()) : tgt,
						$urandom(), $urandom(), $urandom(), $urandom(), 3'($urandom()));
				7:
					send_cmd(CMD_MODIFY, tgt, $urandom(), near_time(), near_time(),
						near_time(), 3'($urandom_range(7)));
				8:
					send_cmd(CMD_SHIFT, tgt, $urandom(), ($urandom_range(3) == 0) ?
						$urandom() : $urandom_range(200), $urandom_range(200),
						$urandom_range(200), 3'($urandom()));
				default:
					send_cmd(3'($urandom_range(7, 5)), 16'($urandom()), $urandom(), $urandom(),
						$urandom(), $urandom(), 3'($urandom()));
			endcase
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every command, not-found, unused codes, extremes of time fields.
		send_cmd(CMD_REMOVE, 16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 3'd0);
		send_cmd(CMD_MODIFY, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 3'd0);
		send_cmd(CMD_SHIFT, 16'd5, 32'd0, 32'd0, 32'd0, 32'd0, 3'd0);
		send_cmd(CMD_TICK, 16'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 3'd0);
		send_cmd(3'd5, 16'hFFFF, '1, '1, '1, '1, 3'd7);
		send_cmd(3'd7, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 3'd0);
		send_cmd(CMD_ADD, 16'd0, 32'd0, 32'd10, 32'd20, 32'd30, REP_DAILY);
		send_cmd(CMD_ADD, 16'd0, 32'd0, 32'd0, 32'd20, 32'd0, 3'd0);
		send_cmd(CMD_ADD, 16'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
		send_cmd(CMD_ADD, 16'd0, 32'd0, 32'd5, 32'd15, 32'd1000, REP_MONTHLY);
		send_cmd(CMD_ADD, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 3'd6);
		send_cmd(CMD_TICK, 16'd0, 32'd12, 32'd0, 32'd0, 32'd0, 3'd0);
		send_cmd(CMD_TICK, 16'd0, 32'd25, 32'd0, 32'd0, 32'd0, 3'd0);
		send_cmd(CMD_REMOVE, 16'd4, 32'd0, 32'd0, 32'd0, 32'd0, 3'd0);
		send_cmd(CMD_SHIFT, 16'd1, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 3'd0);
		send_cmd(CMD_MODIFY, 16'd3, 32'd0, 32'd0, 32'd1, 32'd2, REP_WEEKLY);
		send_cmd(CMD_TICK, 16'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 3'd0);
		for (int i = 0; i < 17; i++)
			send_cmd(CMD_ADD, 16'd0, 32'd0, 32'd50, 32'd0, 32'd0, REP_BIWEEKLY);
		send_cmd(CMD_TICK, 16'd0, 32'd2000000, 32'd0, 32'd0, 32'd0, 3'd0);
		send_cmd(CMD_ADD, 16'd0, 32'd0, 32'd0, 32'd1, 32'd0, REP_FOURWEEKLY);
		drain();

		// Random: three idling regimes.
		random_phase(RANDOM_ITEMS / 3);
		send_idle_pct = 83;
		recv_idle_pct = 10;
		random_phase(RANDOM_ITEMS / 3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(RANDOM_ITEMS / 3);

		drain();
		$display("Sent %0d commands (all codes, full table, id reuse, repeats), checked %0d results.",
			items_sent, results_seen);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

>>> alarm_event_table_core.f
rtl/aet_pkg.sv
rtl/aet_ram.sv
rtl/aet_dir.sv
rtl/alarm_event_table_core.sv
bench/aet_checker.sv
bench/tb.sv
